FILE: sv/acct_pkg.sv
package acct_pkg;

   // Model constants
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int ACC_FRAC        = 20;
   localparam int IN_SCALE        = 24;
   localparam int TABLE_LEN       = 24;

   // Field and datapath widths
   localparam int RAW_W  = 10;
   localparam int ZERO_W = 11;
   localparam int CENT_W = 12;
   localparam int XW     = CENT_W + IN_SCALE + 3;
   localparam int AW     = ACC_FRAC + 12;
   localparam int OUT_W  = 16;
   localparam int STEP_W = $clog2(TABLE_LEN);
   localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int R_W    = AW - RND_SH;

   localparam logic [ZERO_W-1:0] ZERO_G_RESET = ZERO_W'(1023);

   // Angle constants in accumulator units
   localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'd90 << ACC_FRAC);
   localparam logic signed [AW-1:0] HALF_TURN    = AW'(64'd180 << ACC_FRAC);
   localparam logic signed [AW-1:0] FULL_TURN    = AW'(64'd360 << ACC_FRAC);
   localparam logic signed [AW-1:0] ROUND_HALF   = AW'(64'd1 << (RND_SH - 1));
   localparam logic [R_W-1:0]       ANGLE_LIM    = R_W'(64'd360 << ANGLE_FRAC_BITS);
   localparam logic [OUT_W-1:0]     ANGLE_HALF   = OUT_W'(64'd180 << ANGLE_FRAC_BITS);

   typedef struct packed {
      logic [RAW_W-1:0] accel_x;
      logic [RAW_W-1:0] accel_y;
      logic [RAW_W-1:0] accel_z;
   } accel_type;

   typedef struct packed {
      logic [OUT_W-1:0] pitch_angle;
      logic [OUT_W-1:0] yaw_angle;
   } tilt_type;

   // One CORDIC vector in flight; zero_num overrides the rotated angle at the output
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [AW-1:0] acc;
      logic                 zero_num;
      logic                 den_pos;
   } lane_type;

   typedef struct packed {
      lane_type pitch;
      lane_type yaw;
   } pair_type;

   // atan(2^-i) in degrees, 2^-20 units, rounded to nearest
   function automatic logic signed [AW-1:0] atan_of(input logic [STEP_W-1:0] i);
      logic signed [AW-1:0] v;
      case (i)
         STEP_W'(0):  v = AW'(47185920);
         STEP_W'(1):  v = AW'(27855475);
         STEP_W'(2):  v = AW'(14718068);
         STEP_W'(3):  v = AW'(7471121);
         STEP_W'(4):  v = AW'(3750058);
         STEP_W'(5):  v = AW'(1876857);
         STEP_W'(6):  v = AW'(938658);
         STEP_W'(7):  v = AW'(469357);
         STEP_W'(8):  v = AW'(234682);
         STEP_W'(9):  v = AW'(117342);
         STEP_W'(10): v = AW'(58671);
         STEP_W'(11): v = AW'(29335);
         STEP_W'(12): v = AW'(14668);
         STEP_W'(13): v = AW'(7334);
         STEP_W'(14): v = AW'(3667);
         STEP_W'(15): v = AW'(1833);
         STEP_W'(16): v = AW'(917);
         STEP_W'(17): v = AW'(458);
         STEP_W'(18): v = AW'(229);
         STEP_W'(19): v = AW'(115);
         STEP_W'(20): v = AW'(57);
         STEP_W'(21): v = AW'(29);
         STEP_W'(22): v = AW'(14);
         STEP_W'(23): v = AW'(7);
         default:     v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: sv/acct_prep.sv
module acct_prep (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  acct_pkg::accel_type        up_data,
   input  logic [acct_pkg::ZERO_W-1:0] zero_g,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output acct_pkg::pair_type         dn_data
);
   import acct_pkg::*;

   logic     dn_valid_ff;
   pair_type dn_data_ff;
   pair_type dn_data_in;
   logic signed [CENT_W-1:0] cent_x, cent_y, cent_z;

   // Centre and negate a reading in half-LSB units
   function automatic logic signed [CENT_W-1:0] centre(input logic [ZERO_W-1:0] zg,
                                                       input logic [RAW_W-1:0] raw);
      logic signed [CENT_W-1:0] v;
      v = $signed({1'b0, zg}) - $signed({1'b0, raw, 1'b0});
      return v;
   endfunction

   // Pre-rotate the left half-plane and scale up into the CORDIC word
   function automatic lane_type prep_lane(input logic signed [CENT_W-1:0] num,
                                          input logic signed [CENT_W-1:0] den);
      lane_type l;
      logic signed [CENT_W:0] xs, ys;
      xs = {den[CENT_W-1], den};
      ys = {num[CENT_W-1], num};
      l.acc = '0;
      if (den <= 0) begin
         if (num > 0) begin
            xs = {num[CENT_W-1], num};
            ys = -{den[CENT_W-1], den};
            l.acc = QUARTER_TURN;
         end else begin
            xs = -{num[CENT_W-1], num};
            ys = {den[CENT_W-1], den};
            l.acc = -QUARTER_TURN;
         end
      end
      l.x        = XW'(xs) <<< IN_SCALE;
      l.y        = XW'(ys) <<< IN_SCALE;
      l.zero_num = (num == 0);
      l.den_pos  = (den > 0);
      return l;
   endfunction

   // Centred readings and the two vectors
   always_comb begin
      cent_x = centre(zero_g, up_data.accel_x);
      cent_y = centre(zero_g, up_data.accel_y);
      cent_z = centre(zero_g, up_data.accel_z);
      dn_data_in.pitch = prep_lane(cent_y, cent_z);
      dn_data_in.yaw   = prep_lane(cent_x, cent_z);
   end

   assign up_ready = !dn_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (up_ready) begin
         dn_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         dn_data_ff <= dn_data_in;
      end
   end

   assign dn_valid = dn_valid_ff;
   assign dn_data  = dn_data_ff;

endmodule

FILE: sv/acct_cell.sv
module acct_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [acct_pkg::STEP_W-1:0] step,
   input  logic                       up_valid,
   output logic                       up_ready,
   input  acct_pkg::pair_type         up_data,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output acct_pkg::pair_type         dn_data
);
   import acct_pkg::*;

   logic     dn_valid_ff;
   pair_type dn_data_ff;
   pair_type dn_data_in;
   logic signed [AW-1:0] angle;

   // One vectoring micro-rotation with floor shifts
   function automatic lane_type rotate(input lane_type l,
                                       input logic [STEP_W-1:0] s,
                                       input logic signed [AW-1:0] a);
      lane_type r;
      logic signed [XW-1:0] xs, ys;
      xs = l.x >>> s;
      ys = l.y >>> s;
      r = l;
      if (l.y >= 0) begin
         r.x   = l.x + ys;
         r.y   = l.y - xs;
         r.acc = l.acc + a;
      end else begin
         r.x   = l.x - ys;
         r.y   = l.y + xs;
         r.acc = l.acc - a;
      end
      return r;
   endfunction

   always_comb begin
      angle = atan_of(step);
      dn_data_in.pitch = rotate(up_data.pitch, step, angle);
      dn_data_in.yaw   = rotate(up_data.yaw, step, angle);
   end

   assign up_ready = !dn_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dn_valid_ff <= 1'b0;
      end else if (up_ready) begin
         dn_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         dn_data_ff <= dn_data_in;
      end
   end

   assign dn_valid = dn_valid_ff;
   assign dn_data  = dn_data_ff;

endmodule

FILE: sv/acct_out.sv
module acct_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  acct_pkg::pair_type up_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output acct_pkg::tilt_type rsp_data
);
   import acct_pkg::*;

   logic     rsp_valid_ff;
   tilt_type rsp_data_ff;
   tilt_type rsp_data_in;

   // Add half a turn, clamp, round half-up to output units
   function automatic logic [OUT_W-1:0] finish(input lane_type l);
      logic signed [AW-1:0] total;
      logic signed [AW-1:0] rsum;
      logic [R_W-1:0]       r;
      logic [OUT_W-1:0]     res;
      total = l.acc + HALF_TURN;
      if (total < 0) begin
         total = '0;
      end
      if (total > FULL_TURN) begin
         total = FULL_TURN;
      end
      rsum = total + ROUND_HALF;
      r = rsum[AW-1:RND_SH];
      if (r > ANGLE_LIM) begin
         r = ANGLE_LIM;
      end
      res = r[OUT_W-1:0];
      if (l.zero_num) begin
         res = l.den_pos ? ANGLE_HALF : '0;
      end
      return res;
   endfunction

   always_comb begin
      rsp_data_in.pitch_angle = finish(up_data.pitch);
      rsp_data_in.yaw_angle   = finish(up_data.yaw);
   end

   assign up_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (up_ready) begin
         rsp_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: sv/accelerometer_tilt_angles.sv
// Channel   Direction  Handshake        Beat
// req_      in         valid / stall    accel_type: accel_x, accel_y, accel_z
// rsp_      out        valid / stall    tilt_type: pitch_angle, yaw_angle
// csr_      in         valid / ready    zero-g level, half-LSB units (11 bits)
//
// One beat per cycle sustained while rsp_stall is low; the pipe is a prep
// stage, one cell per CORDIC step and a rounding/output register.
// Each stage holds its beat until the next one frees up, so bubbles close
// while rsp_stall is high; req_stall rises only when every stage is full.
// Synchronous reset empties the pipe and loads the zero-g level of 1023.
module accelerometer_tilt_angles (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  acct_pkg::accel_type         req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output acct_pkg::tilt_type          rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [acct_pkg::ZERO_W-1:0] csr_data
);
   import acct_pkg::*;

   logic [ZERO_W-1:0] zero_g_ff;
   logic              req_ready;

   pair_type stage_data  [0:CORDIC_STEPS];
   logic     stage_valid [0:CORDIC_STEPS];
   logic     stage_ready [0:CORDIC_STEPS];

   // Zero-g level register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_g_ff <= ZERO_G_RESET;
      end else if (csr_valid && csr_ready) begin
         zero_g_ff <= csr_data;
      end
   end

   // Centring and quadrant pre-rotation
   acct_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_ready (req_ready),
      .up_data  (req_data),
      .zero_g   (zero_g_ff),
      .dn_valid (stage_valid[0]),
      .dn_ready (stage_ready[0]),
      .dn_data  (stage_data[0])
   );

   assign req_stall = !req_ready;

   // CORDIC chain, one cell per step
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
      acct_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (STEP_W'(g)),
         .up_valid (stage_valid[g]),
         .up_ready (stage_ready[g]),
         .up_data  (stage_data[g]),
         .dn_valid (stage_valid[g+1]),
         .dn_ready (stage_ready[g+1]),
         .dn_data  (stage_data[g+1])
      );
   end

   // Rounding and output register
   acct_out u_out (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (stage_valid[CORDIC_STEPS]),
      .up_ready  (stage_ready[CORDIC_STEPS]),
      .up_data   (stage_data[CORDIC_STEPS]),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
